@@ hdl/b32g_pkg.sv @@
// Shared types, constants and the character decode function of the base32 group decoder.
// No dependencies; every other file of the block but the two interfaces refers to this package by scoped names.
package b32g_pkg;

   // Character codes of the alphabet boundaries, the aliases and the pad.
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
   localparam logic [7:0] CHAR_LO_A  = 8'h61;
   localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
   localparam logic [7:0] CHAR_TWO   = 8'h32;
   localparam logic [7:0] CHAR_SEVEN = 8'h37;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [7:0] CHAR_EIGHT = 8'h38;
   localparam logic [7:0] CHAR_PAD   = 8'h3D;

   // Symbol values of the aliases and of the first digit.
   localparam logic [4:0] VAL_O      = 5'd14;
   localparam logic [4:0] VAL_L      = 5'd11;
   localparam logic [4:0] VAL_B      = 5'd1;
   localparam logic [4:0] VAL_DIGIT0 = 5'd26;

   // Group geometry and pad offsets.
   localparam int          GROUP_CHARS = 8;
   localparam int          GROUP_BITS  = 40;
   localparam logic [2:0]  POS_LAST    = 3'd7;
   localparam logic [3:0]  PAD_NONE    = 4'd8;
   localparam logic [3:0]  PAD_AT_2    = 4'd2;
   localparam logic [3:0]  PAD_AT_4    = 4'd4;
   localparam logic [3:0]  PAD_AT_5    = 4'd5;
   localparam logic [3:0]  PAD_AT_7    = 4'd7;
   localparam logic [2:0]  BYTES_FULL  = 3'd5;

   localparam logic [7:0]  CAP_RESET   = 8'd64;

   // Job queue between the front and back halves.
   localparam int QDEPTH = 2;
   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // One unit of work for the back half: a finished group or an error.
   typedef struct packed {
      logic [GROUP_BITS-1:0] data;     // first byte in the top bits
      logic [2:0]            count;    // bytes to send, 1 to 5
      logic                  last;     // the final byte closes the string
      logic                  err;      // error beat, data is zero
   } job_type;

   // Returns {valid, value} for one character.
   function automatic logic [5:0] sym_decode(input logic [7:0] c);
      logic [5:0] r;
      begin
         r = 6'd0;
         if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
            r = {1'b1, 5'(c - CHAR_UP_A)};
         end else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
            r = {1'b1, 5'(c - CHAR_LO_A)};
         end else if (c >= CHAR_TWO && c <= CHAR_SEVEN) begin
            r = {1'b1, 5'(c - CHAR_TWO) + VAL_DIGIT0};
         end else if (c == CHAR_ZERO) begin
            r = {1'b1, VAL_O};
         end else if (c == CHAR_ONE) begin
            r = {1'b1, VAL_L};
         end else if (c == CHAR_EIGHT) begin
            r = {1'b1, VAL_B};
         end else if (c == CHAR_PAD) begin
            r = {1'b1, 5'd0};
         end
         return r;
      end
   endfunction

endpackage

@@ hdl/b32g_req_if.sv @@
// Input channel of the base32 group decoder: one character per beat.
// No dependencies.
interface b32g_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       final_char;

   modport source (output valid, output char_in, output final_char, input ready);
   modport sink   (input valid, input char_in, input final_char, output ready);
endinterface

@@ hdl/b32g_rsp_if.sv @@
// Result channel of the base32 group decoder: one decoded byte or error per beat.
// No dependencies.
interface b32g_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_out;
   logic       decode_error;

   modport source (output valid, output data_byte, output last_out, output decode_error,
                   input ready);
   modport sink   (input valid, input data_byte, input last_out, input decode_error,
                   output ready);
endinterface

@@ hdl/base32_group_decoder.sv @@
// Top level of the base32 group decoder: front half, job queue and back half.
// Depends on b32g_pkg, b32g_req_if, b32g_rsp_if, b32g_front, b32g_queue and b32g_back.
//
//   Channel   Direction  Beat contents                         Accepted when
//   req_ch    in         char_in, final_char                   valid && ready
//   rsp_ch    out        data_byte, last_out, decode_error     valid && ready
//   csr_*     in         csr_wr_data (out_capacity)            csr_wr_en
//
// The input takes one character per cycle while the queue has room. The front checks each
// character in the cycle it arrives and, when a group of eight closes or an error is found,
// posts one job to a two-entry queue. The back sends a job's bytes one per cycle while rsp_ch
// does not stall. The job of a closing character passes through the queue slot, the back's
// job registers and the output stage before its first byte appears on rsp_ch.
// req_ch.ready falls only when both queue entries are held.
// That happens when the result side stalls, or when short jobs such as error beats arrive
// while the back is still sending a group. Reset is synchronous and active high; it returns
// the capacity to 64 and empties the queue and the output stage.
module base32_group_decoder (
   input  logic        clock,
   input  logic        reset,
   b32g_req_if.sink    req_ch,
   b32g_rsp_if.source  rsp_ch,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   // Jobs travel from the front to the back through the queue.
   b32g_pkg::job_type push_job;
   b32g_pkg::job_type pop_job;
   logic              push;
   logic              pop;
   logic              q_full;
   logic              q_avail;

   // The front decodes characters, tracks the group position, the first pad, the byte count
   // of the string and the discard state after an error.
   b32g_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_full      (q_full),
      .push        (push),
      .push_job    (push_job)
   );

   // The queue lets the front keep taking characters while the back waits on rsp_ch.
   b32g_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (pop),
      .avail    (q_avail),
      .pop_job  (pop_job)
   );

   // The back unpacks each job into beats behind a registered output stage.
   b32g_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_avail (q_avail),
      .q_job   (pop_job),
      .pop     (pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

@@ hdl/b32g_queue.sv @@
// Short job queue between the front (group assembly) and back (byte output) halves.
// Depends on b32g_pkg for the job type and depth.
module b32g_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  b32g_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              avail,
   output b32g_pkg::job_type pop_job
);

   b32g_pkg::job_type                  slot_ff [b32g_pkg::QDEPTH];
   logic [b32g_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [b32g_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [b32g_pkg::QCNT_W-1:0]        cnt_ff, cnt_in;

   function automatic logic [b32g_pkg::QPTR_W-1:0] ptr_next(
      input logic [b32g_pkg::QPTR_W-1:0] p);
      begin
         if (p == b32g_pkg::QPTR_W'(b32g_pkg::QDEPTH - 1)) begin
            return '0;
         end
         return p + 1'b1;
      end
   endfunction

   assign full    = (cnt_ff == b32g_pkg::QCNT_W'(b32g_pkg::QDEPTH));
   assign avail   = (cnt_ff != '0);
   assign pop_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   // The front must never push into a full queue, nor the back pop an empty one.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("job pushed into a full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> avail)
      else $error("job popped from an empty queue");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= b32g_pkg::QCNT_W'(b32g_pkg::QDEPTH))
      else $error("queue fill count out of range");

endmodule

@@ hdl/b32g_front.sv @@
// Front half: accepts characters, checks them, assembles groups and posts jobs.
// Depends on b32g_pkg and the b32g_req_if interface.
module b32g_front (
   input  logic              clock,
   input  logic              reset,
   b32g_req_if.sink          req_ch,
   input  logic              csr_wr_en,
   input  logic [7:0]        csr_wr_data,
   input  logic              q_full,
   output logic              push,
   output b32g_pkg::job_type push_job
);

   logic [7:0] cap_ff;
   logic [2:0] pos_ff, pos_in;
   logic [3:0] pad_ff, pad_in;
   logic [7:0] cnt_ff, cnt_in;
   logic       disc_ff, disc_in;
   logic [4:0] vals_ff [b32g_pkg::GROUP_CHARS-1];

   logic       accept;
   logic       fin;
   logic [5:0] sym;
   logic       is_pad;
   logic [3:0] pad_new;
   logic       err;
   logic       group_done;
   logic [2:0] nbytes;
   logic       wr_val;

   assign req_ch.ready = !q_full;
   assign accept       = req_ch.valid && !q_full;
   assign fin          = req_ch.final_char;
   assign sym          = b32g_pkg::sym_decode(req_ch.char_in);
   assign is_pad       = (req_ch.char_in == b32g_pkg::CHAR_PAD);

   always_comb begin
      pad_new = pad_ff;
      if (is_pad && pad_ff == b32g_pkg::PAD_NONE) begin
         pad_new = {1'b0, pos_ff};
      end

      err = 1'b0;
      if (!sym[5]) begin
         err = 1'b1;
      end else if (is_pad && pad_ff == b32g_pkg::PAD_NONE &&
                   !(pad_new == b32g_pkg::PAD_AT_2 || pad_new == b32g_pkg::PAD_AT_4 ||
                     pad_new == b32g_pkg::PAD_AT_5 || pad_new == b32g_pkg::PAD_AT_7)) begin
         err = 1'b1;
      end else if (!is_pad && pad_ff != b32g_pkg::PAD_NONE) begin
         err = 1'b1;
      end else if (pos_ff != b32g_pkg::POS_LAST) begin
         err = fin;
      end else if (pad_new != b32g_pkg::PAD_NONE && !fin) begin
         err = 1'b1;
      end else if ({1'b0, cnt_ff} + 9'd5 > {1'b0, cap_ff}) begin
         err = 1'b1;
      end

      case (pad_new)
         b32g_pkg::PAD_AT_2: nbytes = 3'd1;
         b32g_pkg::PAD_AT_4: nbytes = 3'd2;
         b32g_pkg::PAD_AT_5: nbytes = 3'd3;
         b32g_pkg::PAD_AT_7: nbytes = 3'd4;
         default:            nbytes = b32g_pkg::BYTES_FULL;
      endcase

      group_done = (pos_ff == b32g_pkg::POS_LAST) && !err;
      wr_val     = accept && !disc_ff && !err && (pos_ff != b32g_pkg::POS_LAST);
      push       = accept && !disc_ff && (err || group_done);

      // The 40 group bits concatenate to the decoded bytes, first byte on top.
      push_job.data  = err ? '0 : {vals_ff[0], vals_ff[1], vals_ff[2], vals_ff[3],
                                   vals_ff[4], vals_ff[5], vals_ff[6], sym[4:0]};
      push_job.count = err ? 3'd1 : nbytes;
      push_job.last  = err || fin;
      push_job.err   = err;

      pos_in  = pos_ff;
      pad_in  = pad_ff;
      cnt_in  = cnt_ff;
      disc_in = disc_ff;
      if (accept) begin
         if (fin) begin
            pos_in  = '0;
            pad_in  = b32g_pkg::PAD_NONE;
            cnt_in  = '0;
            disc_in = 1'b0;
         end else if (disc_ff) begin
            disc_in = 1'b1;
         end else if (err) begin
            disc_in = 1'b1;
         end else if (group_done) begin
            pos_in = '0;
            pad_in = b32g_pkg::PAD_NONE;
            cnt_in = cnt_ff + {5'd0, nbytes};
         end else begin
            pos_in = pos_ff + 1'b1;
            pad_in = pad_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff  <= b32g_pkg::CAP_RESET;
         pos_ff  <= '0;
         pad_ff  <= b32g_pkg::PAD_NONE;
         cnt_ff  <= '0;
         disc_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         pos_ff  <= pos_in;
         pad_ff  <= pad_in;
         cnt_ff  <= cnt_in;
         disc_ff <= disc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_val) begin
         vals_ff[pos_ff] <= sym[4:0];
      end
   end

endmodule

@@ hdl/b32g_back.sv @@
// Back half: takes jobs from the queue and sends their bytes, one per beat,
// through a registered output stage. Depends on b32g_pkg and b32g_rsp_if.
module b32g_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_avail,
   input  b32g_pkg::job_type q_job,
   output logic              pop,
   b32g_rsp_if.source        rsp_ch
);

   logic                            act_ff, act_in;
   logic [b32g_pkg::GROUP_BITS-1:0] data_ff, data_in;
   logic [2:0]                      left_ff, left_in;
   logic                            last_ff, last_in;
   logic                            err_ff, err_in;

   logic                            vld_ff, vld_in;
   logic [7:0]                      byte_ff;
   logic                            lastout_ff;
   logic                            errout_ff;

   logic                            out_free;
   logic                            emit;
   logic                            done;

   always_comb begin
      out_free = !vld_ff || rsp_ch.ready;
      emit     = act_ff && out_free;
      done     = emit && (left_ff == 3'd1);
      pop      = q_avail && (!act_ff || done);

      act_in  = act_ff;
      data_in = data_ff;
      left_in = left_ff;
      last_in = last_ff;
      err_in  = err_ff;
      if (pop) begin
         act_in  = 1'b1;
         data_in = q_job.data;
         left_in = q_job.count;
         last_in = q_job.last;
         err_in  = q_job.err;
      end else if (emit) begin
         act_in  = !done;
         data_in = {data_ff[b32g_pkg::GROUP_BITS-9:0], 8'd0};
         left_in = left_ff - 1'b1;
      end

      vld_in = emit ? 1'b1 : (rsp_ch.ready ? 1'b0 : vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
         vld_ff <= 1'b0;
      end else begin
         act_ff <= act_in;
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      left_ff <= left_in;
      last_ff <= last_in;
      err_ff  <= err_in;
      if (emit) begin
         byte_ff    <= data_ff[b32g_pkg::GROUP_BITS-1 -: 8];
         lastout_ff <= last_ff && (left_ff == 3'd1);
         errout_ff  <= err_ff;
      end
   end

   assign rsp_ch.valid        = vld_ff;
   assign rsp_ch.data_byte    = byte_ff;
   assign rsp_ch.last_out     = lastout_ff;
   assign rsp_ch.decode_error = errout_ff;

   // An error beat is always a lone, closing beat with a zero byte.
   a_err_form: assert property (@(posedge clock) disable iff (reset)
      (vld_ff && errout_ff) |-> (lastout_ff && byte_ff == 8'd0))
      else $error("error beat without last flag or with nonzero data");
   // A job is only taken once the previous one has sent its final byte.
   a_pop_order: assert property (@(posedge clock) disable iff (reset)
      (pop && act_ff) |-> (emit && left_ff == 3'd1))
      else $error("job taken while the previous one still had bytes");

endmodule

@@ test/tb.sv @@
// Self-checking bench for base32_group_decoder: characters in, decoded bytes or error beats out.
// Depends on b32g_pkg, b32g_req_if, b32g_rsp_if and the base32_group_decoder RTL.
module tb;

   // One beat on the result channel, in the order of the channel's payload fields.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       err;
   } rsp_beat_type;

   // One row of the directed table. When err_known is set, the row is expected to give the
   // error beat; that beat is typed in here instead of being taken from the predictor.
   typedef struct packed {
      logic [7:0] ch;
      logic       fin;
      logic       err_known;
   } stim_row_type;

   localparam rsp_beat_type ERR_BEAT   = '{data: 8'h00, last: 1'b1, err: 1'b1};
   localparam int        DRAIN_CYCLES  = 10;
   localparam int        PHASE_CHARS   = 16;
   localparam int        NUM_PHASES    = 4;
   localparam int        IDLE_PERCENT  = 38;

   // The directed part: invalid characters at the code extremes, '{' and a bad length first;
   // then a full group with every alias, both letter cases and the digit extremes; then a
   // pad too early in the group, a letter after a pad, and a padded group that is not final.
   localparam int NUM_ROWS = 28;
   localparam stim_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      '{8'hFF, 1'b1, 1'b1}, '{8'h00, 1'b1, 1'b1}, '{"{", 1'b1, 1'b1}, '{"q", 1'b1, 1'b1},
      '{"0", 1'b0, 1'b0}, '{"1", 1'b0, 1'b0}, '{"8", 1'b0, 1'b0}, '{"a", 1'b0, 1'b0},
      '{"Z", 1'b0, 1'b0}, '{"2", 1'b0, 1'b0}, '{"7", 1'b0, 1'b0}, '{"z", 1'b1, 1'b0},
      '{"A", 1'b0, 1'b0}, '{"=", 1'b0, 1'b1}, '{"B", 1'b1, 1'b0},
      '{"A", 1'b0, 1'b0}, '{"B", 1'b0, 1'b0}, '{"=", 1'b0, 1'b0}, '{"C", 1'b0, 1'b1},
      '{"D", 1'b1, 1'b0},
      '{"A", 1'b0, 1'b0}, '{"B", 1'b0, 1'b0}, '{"C", 1'b0, 1'b0}, '{"D", 1'b0, 1'b0},
      '{"=", 1'b0, 1'b0}, '{"=", 1'b0, 1'b0}, '{"=", 1'b0, 1'b0}, '{"=", 1'b0, 1'b1}
   };

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic [7:0] csr_wr_data;

   b32g_req_if req_ch ();
   b32g_rsp_if rsp_ch ();

   base32_group_decoder u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Predictor state: a private copy of the decoder's group registers and its capacity.
   logic [4:0] grp_vals [8];
   logic [2:0] grp_pos;
   logic [3:0] pad_at;
   logic [7:0] str_bytes;
   logic       skipping;
   logic [7:0] capacity;

   rsp_beat_type new_beats [$];   // beats caused by the character just decoded
   rsp_beat_type bytes_due [$];   // beats still owed by the decoder, oldest first
   int         fail_count;
   int         chars_decoded;   // characters that were not merely discarded
   bit         idle_on;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // The run is far shorter than this; reaching it means the decoder hung or lost beats.
   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // Symbol value of one character, or -1 when the character is outside the alphabet.
   function automatic int symbol_value(input logic [7:0] c);
      if (c >= b32g_pkg::CHAR_UP_A && c <= b32g_pkg::CHAR_UP_Z)
         return int'(c - b32g_pkg::CHAR_UP_A);
      if (c >= b32g_pkg::CHAR_LO_A && c <= b32g_pkg::CHAR_LO_Z)
         return int'(c - b32g_pkg::CHAR_LO_A);
      if (c >= b32g_pkg::CHAR_TWO && c <= b32g_pkg::CHAR_SEVEN)
         return int'(c - b32g_pkg::CHAR_TWO) + int'(b32g_pkg::VAL_DIGIT0);
      if (c == b32g_pkg::CHAR_ZERO) return int'(b32g_pkg::VAL_O);
      if (c == b32g_pkg::CHAR_ONE) return int'(b32g_pkg::VAL_L);
      if (c == b32g_pkg::CHAR_EIGHT) return int'(b32g_pkg::VAL_B);
      if (c == b32g_pkg::CHAR_PAD) return 0;
      return -1;
   endfunction

   function automatic void restart_string();
      grp_pos   = '0;
      pad_at    = b32g_pkg::PAD_NONE;
      str_bytes = '0;
      skipping  = 1'b0;
   endfunction

   // A rejected string gives one error beat. On the final character the next string starts
   // at once; otherwise the rest of the string is skipped up to its final character.
   function automatic void reject_string(input logic fin);
      new_beats.push_back(ERR_BEAT);
      if (fin) restart_string();
      else skipping = 1'b1;
   endfunction

   // Works out the beats one accepted character causes and advances the predictor state.
   function automatic void decode_char(input logic [7:0] c, input logic fin);
      int          sym;
      int          nbytes;
      logic [39:0] bits;
      logic [3:0]  pos4;
      new_beats.delete();
      if (skipping) begin
         if (fin) restart_string();
         return;
      end
      chars_decoded++;
      sym  = symbol_value(c);
      pos4 = {1'b0, grp_pos};
      if (sym < 0) begin
         reject_string(fin);
         return;
      end
      if (c == b32g_pkg::CHAR_PAD) begin
         // Only the first pad of a group is checked for its place.
         if (pad_at == b32g_pkg::PAD_NONE) begin
            if (pos4 != b32g_pkg::PAD_AT_2 && pos4 != b32g_pkg::PAD_AT_4 &&
                pos4 != b32g_pkg::PAD_AT_5 && pos4 != b32g_pkg::PAD_AT_7) begin
               reject_string(fin);
               return;
            end
            pad_at = pos4;
         end
      end else if (pad_at != b32g_pkg::PAD_NONE) begin
         reject_string(fin);
         return;
      end
      grp_vals[grp_pos] = 5'(sym);
      if (grp_pos != b32g_pkg::POS_LAST) begin
         if (fin) begin
            reject_string(fin);
            return;
         end
         grp_pos = grp_pos + 3'd1;
         return;
      end
      // The group is complete: padding is allowed only in the final group, and the whole
      // five bytes must fit under the capacity even when fewer are sent.
      if (pad_at != b32g_pkg::PAD_NONE && !fin) begin
         reject_string(fin);
         return;
      end
      if (int'(str_bytes) + 5 > int'(capacity)) begin
         reject_string(fin);
         return;
      end
      case (pad_at)
         b32g_pkg::PAD_AT_2: nbytes = 1;
         b32g_pkg::PAD_AT_4: nbytes = 2;
         b32g_pkg::PAD_AT_5: nbytes = 3;
         b32g_pkg::PAD_AT_7: nbytes = 4;
         default:            nbytes = 5;
      endcase
      bits = {grp_vals[0], grp_vals[1], grp_vals[2], grp_vals[3],
              grp_vals[4], grp_vals[5], grp_vals[6], grp_vals[7]};
      for (int k = 0; k < nbytes; k++) begin
         new_beats.push_back('{data: bits[39 - 8 * k -: 8],
                               last: fin && (k == nbytes - 1), err: 1'b0});
      end
      str_bytes = str_bytes + 8'(nbytes);
      if (fin) begin
         restart_string();
      end else begin
         grp_pos = '0;
         pad_at  = b32g_pkg::PAD_NONE;
      end
   endfunction

   // A random character of the alphabet, aliases included, never the pad.
   function automatic logic [7:0] any_symbol();
      case ($urandom_range(0, 4))
         0:       return 8'(b32g_pkg::CHAR_LO_A + $urandom_range(0, 25));
         1:       return 8'(b32g_pkg::CHAR_TWO + $urandom_range(0, 5));
         2: begin
            case ($urandom_range(0, 2))
               0:       return b32g_pkg::CHAR_ZERO;
               1:       return b32g_pkg::CHAR_ONE;
               default: return b32g_pkg::CHAR_EIGHT;
            endcase
         end
         default: return 8'(b32g_pkg::CHAR_UP_A + $urandom_range(0, 25));
      endcase
   endfunction

   // Sends one character beat, with random gaps ahead of it when idling is on. Valid is left
   // high after the accepting edge, so a back-to-back beat never lowers and raises it in one
   // step; the next call or the drain decides what valid does next.
   task automatic send_char(input logic [7:0] c, input logic fin, input logic err_known);
      while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.char_in    <= c;
      req_ch.final_char <= fin;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      // The beat was taken at this edge.
      decode_char(c, fin);
      if (err_known) bytes_due.push_back(ERR_BEAT);
      else foreach (new_beats[i]) bytes_due.push_back(new_beats[i]);
   endtask

   // Most strings are well formed with random content; about a third are broken on purpose,
   // and now and then a lone random byte stands in for noise on the line.
   task automatic send_string();
      logic [7:0] text [$];
      int         groups;
      int         pad_from;
      int         g;
      int         p;
      if ($urandom_range(0, 99) < 10) begin
         send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
         return;
      end
      groups = ($urandom_range(0, 9) == 0) ? 4 : $urandom_range(1, 3);
      case ($urandom_range(0, 4))
         0:       pad_from = 2;
         1:       pad_from = 4;
         2:       pad_from = 5;
         3:       pad_from = 7;
         default: pad_from = 8;
      endcase
      for (int gi = 0; gi < groups; gi++) begin
         for (int pi = 0; pi < 8; pi++) begin
            text.push_back((gi == groups - 1 && pi >= pad_from) ? b32g_pkg::CHAR_PAD
                                                                : any_symbol());
         end
      end
      if ($urandom_range(0, 99) < 33) begin
         case ($urandom_range(0, 4))
            // Any byte at all in a random place.
            0: text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
            // Cut short, so the final character falls inside a group.
            1: repeat ($urandom_range(1, 7)) void'(text.pop_back());
            // Pad the tail of a random group from a random offset: a bad pad place, or
            // padding in a group that is not the last one.
            2: begin
               g = $urandom_range(0, groups - 1);
               p = $urandom_range(0, 7);
               for (int k = g * 8 + p; k < g * 8 + 8; k++) text[k] = b32g_pkg::CHAR_PAD;
            end
            // A letter after the first pad, or a stray pad in an unpadded string.
            3: begin
               if (pad_from < 8) text[text.size() - 1] = any_symbol();
               else text[$urandom_range(0, text.size() - 1)] = b32g_pkg::CHAR_PAD;
            end
            // Overlong, so the string ends part way into an extra group.
            default: repeat ($urandom_range(1, 3)) text.push_back(any_symbol());
         endcase
      end
      foreach (text[i]) send_char(text[i], i == text.size() - 1, 1'b0);
   endtask

   // Holds the input idle until every owed beat has come out, then lets the decoder settle.
   // Discarded characters leave no beat behind, so the extra cycles cover any work in flight.
   task automatic drain_decoder();
      req_ch.valid <= 1'b0;
      while (bytes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_capacity(input logic [7:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      capacity   = value;
      csr_wr_en <= 1'b0;
   endtask

   // Result side: checks every accepted beat against the oldest owed one and stalls at
   // random whenever idling is on.
   initial begin
      rsp_beat_type got;
      rsp_beat_type want;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            got = '{data: rsp_ch.data_byte, last: rsp_ch.last_out, err: rsp_ch.decode_error};
            if (bytes_due.size() == 0) begin
               $error("unexpected beat: data_byte %02h last_out %0b decode_error %0b",
                      got.data, got.last, got.err);
               fail_count++;
            end else begin
               want = bytes_due.pop_front();
               if (got.data != want.data) begin
                  $error("data_byte: expected %02h, got %02h", want.data, got.data);
                  fail_count++;
               end
               if (got.last != want.last) begin
                  $error("last_out: expected %0b, got %0b", want.last, got.last);
                  fail_count++;
               end
               if (got.err != want.err) begin
                  $error("decode_error: expected %0b, got %0b", want.err, got.err);
                  fail_count++;
               end
            end
         end
         rsp_ch.ready <= !(idle_on && $urandom_range(0, 99) < IDLE_PERCENT);
      end
   end

   // Stimulus: reset, the directed table at the reset capacity, then random phases at
   // several capacities. Every phase boundary doubles as the pause in which the sender
   // waits for all owed beats before it goes on.
   initial begin
      logic [7:0] phase_cap;
      int         phase_start;
      reset             <= 1'b1;
      csr_wr_en         <= 1'b0;
      csr_wr_data       <= '0;
      req_ch.valid      <= 1'b0;
      req_ch.char_in    <= '0;
      req_ch.final_char <= 1'b0;
      fail_count    = 0;
      chars_decoded = 0;
      idle_on       = 1'b1;
      capacity      = b32g_pkg::CAP_RESET;
      for (int i = 0; i < 8; i++) grp_vals[i] = '0;
      restart_string();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         send_char(DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].fin, DIRECTED_ROWS[i].err_known);
      end
      drain_decoder();

      // The first random phase runs with no idling on either side; the capacity of zero
      // rejects every group, and the small ones reject the later groups of a string.
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0:       phase_cap = 8'd255;
            1:       phase_cap = 8'd0;
            2:       phase_cap = 8'd13;
            default: phase_cap = 8'($urandom_range(5, 30));
         endcase
         set_capacity(phase_cap);
         idle_on     = (ph != 0);
         phase_start = chars_decoded;
         while (chars_decoded - phase_start < PHASE_CHARS) send_string();
         drain_decoder();
      end

      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
